@@ src/bda_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Brightness to dimming alpha: shared package
// Field widths, divider sizing and the stock breakpoint table.
// ----------------------------------------------------------------------------
package bda_pkg;

  localparam int LEVEL_W       = 11;
  localparam int ALPHA_W       = 8;
  localparam int X_W           = 12;
  localparam int IN_TDATA_W    = 16;
  localparam int OUT_TDATA_W   = 8;
  localparam int BDA_ENTRIES   = 21;

  localparam int DIV_W         = 21;
  localparam int DVS_W         = 11;
  localparam int DIV_STEP_BITS = 4;
  localparam int DIV_STEPS     = (DIV_W + DIV_STEP_BITS - 1) / DIV_STEP_BITS;
  localparam int DIV_PAD_W     = DIV_STEPS * DIV_STEP_BITS;
  localparam int DIV_CNT_W     = $clog2(DIV_STEPS);
  localparam int MAG_W         = DIV_W + 1;
  localparam int RES_W         = MAG_W + 2;

  typedef struct packed {
    logic [LEVEL_W-1:0] level;
    logic [ALPHA_W-1:0] alpha;
  } bp_t;

  // Entries beyond the stock pairs return level 2000 with alpha 8'h83.
  function automatic bp_t bp_entry(input int unsigned idx);
    bp_t e;
    unique case (idx)
      0:       e = '{level: 11'd0,    alpha: 8'hff};
      1:       e = '{level: 11'd1,    alpha: 8'hf1};
      2:       e = '{level: 11'd2,    alpha: 8'hf0};
      3:       e = '{level: 11'd3,    alpha: 8'hee};
      4:       e = '{level: 11'd4,    alpha: 8'hec};
      5:       e = '{level: 11'd6,    alpha: 8'heb};
      6:       e = '{level: 11'd10,   alpha: 8'he7};
      7:       e = '{level: 11'd20,   alpha: 8'hdf};
      8:       e = '{level: 11'd30,   alpha: 8'hd8};
      9:       e = '{level: 11'd45,   alpha: 8'hd0};
      10:      e = '{level: 11'd70,   alpha: 8'hc5};
      11:      e = '{level: 11'd100,  alpha: 8'hb9};
      12:      e = '{level: 11'd150,  alpha: 8'haf};
      13:      e = '{level: 11'd227,  alpha: 8'h99};
      14:      e = '{level: 11'd300,  alpha: 8'h88};
      15:      e = '{level: 11'd400,  alpha: 8'h76};
      16:      e = '{level: 11'd500,  alpha: 8'h66};
      17:      e = '{level: 11'd600,  alpha: 8'h59};
      18:      e = '{level: 11'd800,  alpha: 8'h42};
      19:      e = '{level: 11'd1023, alpha: 8'h2a};
      default: e = '{level: 11'd2000, alpha: 8'h83};
    endcase
    return e;
  endfunction

endpackage
`default_nettype wire

@@ src/brightness_to_dim_alpha_top.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Brightness to dimming alpha
// Maps a backlight level to an overlay alpha by piecewise interpolation.
// ----------------------------------------------------------------------------
// One level is handled at a time. The breakpoint table sits behind a single
// registered read port: a binary search probes it, one probe per SEEK and
// TEST state pair (four or five probes for 21 entries), then the RDA, RDB and
// LATB states fetch the two neighbouring breakpoints. A level between
// breakpoints then passes through PROD, which forms the operands, GO1, which
// starts the four-bit-a-cycle dividers, and two division rounds in DIV1 and
// DIV2 before its result is presented; a level at or below the first or above
// the last breakpoint goes from LATB straight to DONE. A new level is taken
// while the previous result still waits in the output register.
module brightness_to_dim_alpha_top #(
  parameter int TABLE_ENTRIES = bda_pkg::BDA_ENTRIES
) (
  input  wire                               clk,
  input  wire                               rst,
  input  wire                               s_tvalid,
  output logic                              s_tready,
  input  wire  [bda_pkg::IN_TDATA_W-1:0]    s_tdata,  // [11:0] panel_level
  output logic                              m_tvalid,
  input  wire                               m_tready,
  output logic [bda_pkg::OUT_TDATA_W-1:0]   m_tdata   // [7:0] alpha
);
  import bda_pkg::*;

  localparam int IDX_W = $clog2(TABLE_ENTRIES);
  localparam int K_W   = $clog2(TABLE_ENTRIES + 1);

  typedef enum logic [3:0] {
    ST_IDLE, ST_SEEK, ST_TEST, ST_RDA, ST_RDB, ST_LATB,
    ST_PROD, ST_GO1, ST_DIV1, ST_DIV2, ST_DONE
  } state_t;

  state_t             state;
  logic [X_W-1:0]     x;
  logic [K_W-1:0]     lo;
  logic [K_W-1:0]     hi;
  logic [K_W:0]       lo_hi_sum;
  logic [IDX_W-1:0]   mid;
  logic [IDX_W-1:0]   addr_a;
  logic [IDX_W-1:0]   addr_b;
  logic [IDX_W-1:0]   rom_addr;
  bp_t                rom_q;
  logic [LEVEL_W-1:0] xa;
  logic [LEVEL_W-1:0] xb;
  logic [ALPHA_W-1:0] ya;
  logic [ALPHA_W-1:0] yb;
  logic [DVS_W-1:0]   dx;
  logic [ALPHA_W-1:0] dy_mag;
  logic               dy_neg;
  logic               dy_zero;
  logic [DIV_W-1:0]   twice_num;
  logic [DIV_W-1:0]   corr_num;
  logic [DIV_W-1:0]   half;
  logic [ALPHA_W-1:0] result;

  logic [LEVEL_W-1:0]   dxa;
  logic [LEVEL_W-1:0]   dxb;
  logic [2*LEVEL_W-1:0] corr_prod;
  logic [DIV_W-3:0]     twice_prod;
  logic [MAG_W-1:0]     mag;
  logic [RES_W-1:0]     res_s;

  logic               t_done;
  logic [DIV_W-1:0]   t_q;
  logic               c_start;
  logic [DIV_W-1:0]   c_dvd;
  logic [DVS_W-1:0]   c_dvs;
  logic               c_done;
  logic [DIV_W-1:0]   c_q;

  assign s_tready  = (state == ST_IDLE);
  assign lo_hi_sum = {1'b0, lo} + {1'b0, hi};
  assign mid       = IDX_W'(lo_hi_sum >> 1);
  assign addr_a    = (lo == '0) ? '0 : IDX_W'(lo - 1'b1);
  assign addr_b    = (lo == K_W'(TABLE_ENTRIES)) ? IDX_W'(TABLE_ENTRIES - 1) : IDX_W'(lo);

  always_comb begin
    case (state)
      ST_RDA:  rom_addr = addr_a;
      ST_RDB:  rom_addr = addr_b;
      default: rom_addr = mid;
    endcase
  end

  assign dxa        = x[LEVEL_W-1:0] - xa;
  assign dxb        = xb - x[LEVEL_W-1:0];
  assign corr_prod  = (2*LEVEL_W)'(dxa) * (2*LEVEL_W)'(dxb);
  assign twice_prod = (DIV_W-2)'(dy_mag) * (DIV_W-2)'(dxa);
  assign twice_num  = DIV_W'({twice_prod, 1'b0});
  assign corr_num   = DIV_W'({corr_prod, 1'b0});

  assign c_start = (state == ST_GO1) || (state == ST_DIV1 && c_done);
  assign c_dvd   = (state == ST_GO1) ? corr_num : c_q;
  assign c_dvs   = (state == ST_GO1) ? DVS_W'(dy_mag) : dx;

  assign mag   = {1'b0, half} + (dy_zero ? '0 : {1'b0, c_q});
  assign res_s = dy_neg ? RES_W'(ya) - RES_W'(mag) : RES_W'(ya) + RES_W'(mag);

  bda_rom #(
    .ENTRIES (TABLE_ENTRIES)
  ) u_rom (
    .clk  (clk),
    .addr (rom_addr),
    .q    (rom_q)
  );

  bda_div u_div_twice (
    .clk      (clk),
    .rst      (rst),
    .start    (state == ST_GO1),
    .dividend (twice_num),
    .divisor  (dx),
    .done     (t_done),
    .quotient (t_q)
  );

  bda_div u_div_corr (
    .clk      (clk),
    .rst      (rst),
    .start    (c_start),
    .dividend (c_dvd),
    .divisor  (c_dvs),
    .done     (c_done),
    .quotient (c_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
      lo       <= '0;
      hi       <= '0;
    end else begin
      if (m_tvalid && m_tready && state != ST_DONE) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            x     <= s_tdata[X_W-1:0];
            lo    <= '0;
            hi    <= K_W'(TABLE_ENTRIES);
            state <= ST_SEEK;
          end
        end
        ST_SEEK: begin
          state <= (lo < hi) ? ST_TEST : ST_RDA;
        end
        ST_TEST: begin
          if ({1'b0, rom_q.level} >= x) begin
            hi <= K_W'(mid);
          end else begin
            lo <= K_W'(mid) + 1'b1;
          end
          state <= ST_SEEK;
        end
        ST_RDA: begin
          state <= ST_RDB;
        end
        ST_RDB: begin
          xa    <= rom_q.level;
          ya    <= rom_q.alpha;
          state <= ST_LATB;
        end
        ST_LATB: begin
          xb <= rom_q.level;
          yb <= rom_q.alpha;
          if (lo == '0) begin
            result <= ya;
            state  <= ST_DONE;
          end else if (lo == K_W'(TABLE_ENTRIES)) begin
            result <= rom_q.alpha;
            state  <= ST_DONE;
          end else begin
            state <= ST_PROD;
          end
        end
        ST_PROD: begin
          dx        <= DVS_W'(xb - xa);
          dy_neg    <= (yb < ya);
          dy_zero   <= (yb == ya);
          dy_mag    <= (yb < ya) ? ya - yb : yb - ya;
          state     <= ST_GO1;
        end
        ST_GO1: begin
          state <= ST_DIV1;
        end
        ST_DIV1: begin
          if (c_done) begin
            half  <= DIV_W'((t_q >> 1) + DIV_W'(t_q[0]));
            state <= ST_DIV2;
          end
        end
        ST_DIV2: begin
          if (c_done) begin
            if (res_s[RES_W-1]) begin
              result <= '0;
            end else if (res_s > RES_W'(255)) begin
              result <= '1;
            end else begin
              result <= res_s[ALPHA_W-1:0];
            end
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= result;
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input taken while a level was still in work");

  a_div_lockstep: assert property (@(posedge clk) disable iff (rst)
    t_done |-> c_done)
    else $error("dividers lost step");

  a_div_in_state: assert property (@(posedge clk) disable iff (rst)
    c_done |-> (state == ST_DIV1 || state == ST_DIV2))
    else $error("division finished outside the division states");

  a_search_bounds: assert property (@(posedge clk) disable iff (rst)
    state == ST_SEEK |-> lo <= hi && hi <= K_W'(TABLE_ENTRIES))
    else $error("search window out of range");
`endif

endmodule
`default_nettype wire

@@ src/bda_rom.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Breakpoint table
// Synchronous read-only table of brightness and alpha pairs, one read a cycle.
// ----------------------------------------------------------------------------
module bda_rom #(
  parameter int ENTRIES = bda_pkg::BDA_ENTRIES
) (
  input  wire                          clk,
  input  wire  [$clog2(ENTRIES)-1:0]   addr,
  output bda_pkg::bp_t                 q
);
  import bda_pkg::*;

  bp_t rom_mem [ENTRIES];

  for (genvar i = 0; i < ENTRIES; i++) begin : g_fill
    assign rom_mem[i] = bp_entry(i);
  end

  always_ff @(posedge clk) begin
    q <= rom_mem[addr];
  end

endmodule
`default_nettype wire

@@ src/bda_div.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Iterative unsigned divider
// Restoring division, several quotient bits per cycle, truncating quotient.
// ----------------------------------------------------------------------------
module bda_div (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          start,
  input  wire  [bda_pkg::DIV_W-1:0]    dividend,
  input  wire  [bda_pkg::DVS_W-1:0]    divisor,
  output logic                         done,
  output logic [bda_pkg::DIV_W-1:0]    quotient
);
  import bda_pkg::*;

  logic                 busy;
  logic [DIV_CNT_W-1:0] cnt;
  logic [DVS_W-1:0]     rem;
  logic [DVS_W-1:0]     rem_next;
  logic [DVS_W-1:0]     dvs;
  logic [DIV_PAD_W-1:0] quo;
  logic [DIV_PAD_W-1:0] quo_next;

  always_comb begin
    logic [DVS_W-1:0]     r;
    logic [DIV_PAD_W-1:0] q;
    logic [DVS_W:0]       t;
    r = rem;
    q = quo;
    for (int i = 0; i < DIV_STEP_BITS; i++) begin
      t = {r, q[DIV_PAD_W-1]};
      q = {q[DIV_PAD_W-2:0], 1'b0};
      if (t >= {1'b0, dvs}) begin
        r    = DVS_W'(t - {1'b0, dvs});
        q[0] = 1'b1;
      end else begin
        r = t[DVS_W-1:0];
      end
    end
    rem_next = r;
    quo_next = q;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= DIV_CNT_W'(DIV_STEPS - 1);
        rem  <= '0;
        dvs  <= divisor;
        quo  <= DIV_PAD_W'(dividend);
      end else if (busy) begin
        rem <= rem_next;
        quo <= quo_next;
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient = quo[DIV_W-1:0];

endmodule
`default_nettype wire
